// ===== src/gfm_pkg.sv =====
// Shared types, constants and helper functions for the greedy face mask merger.
`timescale 1ns / 1ps
package gfm_pkg;

    // Default mask dimensions.
    localparam int MaskUDef = 8;
    localparam int MaskVDef = 8;

    // Width of coordinate and extent counters (holds 0 to 8).
    localparam int CW = 4;

    // Byte address of the water texture register.
    localparam logic [2:0] AddrWater = 3'd0;

    // Reset value of the water texture register.
    localparam logic [7:0] WaterReset = 8'd5;

    // One stored cell: face code in bits 7..0, corner k level in bits 9+2k..8+2k.
    typedef logic [15:0] t_cell;

    typedef struct packed {
        logic [7:0]  face_code;
        logic [11:0] occluders;
        logic        last_cell;
    } t_in_item;

    typedef struct packed {
        logic [2:0] start_u;
        logic [2:0] start_v;
        logic [3:0] extent_u;
        logic [3:0] extent_v;
        logic [7:0] texture;
        logic [1:0] level_c0;
        logic [1:0] level_c1;
        logic [1:0] level_c2;
        logic [1:0] level_c3;
        logic       diagonal_flip;
        logic       water_face;
        logic       last_rect;
    } t_out_item;

    // Result offered by the sequencer to the output register.
    typedef struct packed {
        logic      valid;
        t_out_item item;
    } t_push;

    // Occlusion level of one corner from side one, side two and diagonal bits.
    function automatic logic [1:0] corner_level(input logic [2:0] bits);
        logic [1:0] lvl;
        if (bits[0] && bits[1]) begin
            lvl = 2'd0;
        end else begin
            lvl = 2'd3 - {1'b0, bits[0]} - {1'b0, bits[1]} - {1'b0, bits[2]};
        end
        return lvl;
    endfunction

    // Pack face code and four corner levels into one stored cell.
    function automatic t_cell encode_cell(input logic [7:0] code, input logic [11:0] occ);
        t_cell c;
        c[7:0] = code;
        for (int k = 0; k < 4; k++) begin
            c[8 + 2 * k +: 2] = corner_level(occ[3 * k +: 3]);
        end
        return c;
    endfunction

    // Format one rectangle as a result item.
    function automatic t_out_item make_result(
        input logic [CW-1:0] su,
        input logic [CW-1:0] sv,
        input logic [CW-1:0] eu,
        input logic [CW-1:0] ev,
        input t_cell         c,
        input logic [7:0]    water,
        input logic          last
    );
        t_out_item r;
        r.start_u       = su[2:0];
        r.start_v       = sv[2:0];
        r.extent_u      = eu;
        r.extent_v      = ev;
        r.texture       = c[7:0] - 8'd1;
        r.level_c0      = c[9:8];
        r.level_c1      = c[11:10];
        r.level_c2      = c[13:12];
        r.level_c3      = c[15:14];
        r.diagonal_flip = ({1'b0, c[9:8]} + {1'b0, c[13:12]}) >
                          ({1'b0, c[11:10]} + {1'b0, c[15:14]});
        r.water_face    = (r.texture == water);
        r.last_rect     = last;
        return r;
    endfunction

endpackage

// ===== src/gfm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module gfm_ram #(
    parameter int W = 16,
    parameter int D = 64
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/gfm_merge_seq.sv =====
// Merge sequencer: scans the mask and grows rectangles through one compare unit.
`timescale 1ns / 1ps
module gfm_merge_seq #(
    parameter int MASK_U = gfm_pkg::MaskUDef,
    parameter int MASK_V = gfm_pkg::MaskVDef
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [7:0]                        i_water,
    output logic [$clog2(MASK_U*MASK_V)-1:0]  o_rd_addr,
    input  gfm_pkg::t_cell                    i_rd_data,
    output gfm_pkg::t_push                    o_push,
    input  logic                              i_push_ready,
    output logic                              o_busy
);
    import gfm_pkg::*;

    localparam int Cells = MASK_U * MASK_V;
    localparam int AW    = $clog2(Cells);
    localparam int AXW   = AW + 1;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_SCAN_CHK,
        S_GU,
        S_GU_CHK,
        S_GV,
        S_GV_CHK,
        S_MARK,
        S_PUSH,
        S_FINAL
    } t_state;

    t_state          r_state;
    logic [CW-1:0]   r_iu, r_iv, r_w, r_h, r_ju, r_mv;
    logic [AW-1:0]   r_clr;
    t_cell           r_ref;
    logic            r_pend_v;
    logic [CW-1:0]   r_pend_su, r_pend_sv, r_pend_eu, r_pend_ev;
    t_cell           r_pend_cell;

    logic [AXW-1:0]  a_full;
    logic            vis;
    logic            take;
    logic            gu_ok, gv_ok;
    logic            last_u, scan_end;
    logic            v_we;
    logic [AW-1:0]   v_waddr;
    logic [0:0]      v_wdata;
    logic [0:0]      v_rdata;
    t_out_item       empty_item;

    // Address of the cell under test or being marked, picked by the sequencer state.
    always_comb begin
        unique case (r_state)
            S_GU:    a_full = AXW'(r_iv) * AXW'(MASK_U) + AXW'(r_iu) + AXW'(r_w);
            S_GV:    a_full = (AXW'(r_iv) + AXW'(r_h)) * AXW'(MASK_U)
                              + AXW'(r_iu) + AXW'(r_ju);
            S_MARK:  a_full = (AXW'(r_iv) + AXW'(r_mv)) * AXW'(MASK_U)
                              + AXW'(r_iu) + AXW'(r_ju);
            default: a_full = AXW'(r_iv) * AXW'(MASK_U) + AXW'(r_iu);
        endcase
    end

    assign o_rd_addr = a_full[AW-1:0];
    assign vis       = v_rdata[0];
    assign take      = !vis && (i_rd_data[7:0] != 8'd0);
    assign gu_ok     = ({1'b0, r_iu} + {1'b0, r_w}) < (CW+1)'(MASK_U);
    assign gv_ok     = ({1'b0, r_iv} + {1'b0, r_h}) < (CW+1)'(MASK_V);
    assign last_u    = (r_iu == CW'(MASK_U - 1));
    assign scan_end  = last_u && (r_iv == CW'(MASK_V - 1));

    // Visited map writes. The scan clears each cell as it leaves it, so the map is
    // all zero again once a merge ends; the origin of a rectangle is written zero
    // during marking for the same reason. After reset a clearing pass zeroes it.
    always_comb begin
        v_we    = 1'b0;
        v_waddr = o_rd_addr;
        v_wdata = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                v_we    = 1'b1;
                v_waddr = r_clr;
            end
            S_SCAN_CHK: begin
                v_we = !take;
            end
            S_MARK: begin
                v_we    = 1'b1;
                v_wdata = (r_ju != '0) || (r_mv != '0);
            end
            default: begin
                v_we = 1'b0;
            end
        endcase
    end

    // Visited map, read at the same address as the cell store.
    gfm_ram #(.W(1), .D(Cells)) u_visited (
        .i_clk   (i_clk),
        .i_we    (v_we),
        .i_waddr (v_waddr),
        .i_wdata (v_wdata),
        .i_raddr (o_rd_addr),
        .o_rdata (v_rdata)
    );

    // Result offered downstream: the pending rectangle, or the empty-mask marker.
    always_comb begin
        empty_item           = '0;
        empty_item.last_rect = 1'b1;
        o_push.valid = (r_state == S_PUSH) || (r_state == S_FINAL);
        if (r_pend_v) begin
            o_push.item = make_result(r_pend_su, r_pend_sv, r_pend_eu, r_pend_ev,
                                      r_pend_cell, i_water, r_state == S_FINAL);
        end else begin
            o_push.item = empty_item;
        end
    end

    assign o_busy = (r_state != S_IDLE);

    // Sequencer state and working registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_pend_v <= 1'b0;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    if (r_clr == AW'(Cells - 1)) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_clr <= r_clr + AW'(1);
                    end
                end
                S_IDLE: begin
                    if (i_start) begin
                        r_pend_v  <= 1'b0;
                        r_iu      <= '0;
                        r_iv      <= '0;
                        r_state   <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_state <= S_SCAN_CHK;
                end
                S_SCAN_CHK: begin
                    if (take) begin
                        r_ref   <= i_rd_data;
                        r_w     <= CW'(1);
                        r_state <= S_GU;
                    end else if (scan_end) begin
                        r_state <= S_FINAL;
                    end else begin
                        r_iu    <= last_u ? '0 : r_iu + CW'(1);
                        r_iv    <= last_u ? r_iv + CW'(1) : r_iv;
                        r_state <= S_SCAN;
                    end
                end
                S_GU: begin
                    if (gu_ok) begin
                        r_state <= S_GU_CHK;
                    end else begin
                        r_h     <= CW'(1);
                        r_ju    <= '0;
                        r_state <= S_GV;
                    end
                end
                S_GU_CHK: begin
                    if (!vis && i_rd_data == r_ref) begin
                        r_w     <= r_w + CW'(1);
                        r_state <= S_GU;
                    end else begin
                        r_h     <= CW'(1);
                        r_ju    <= '0;
                        r_state <= S_GV;
                    end
                end
                S_GV: begin
                    if (gv_ok) begin
                        r_state <= S_GV_CHK;
                    end else begin
                        r_ju    <= '0;
                        r_mv    <= '0;
                        r_state <= S_MARK;
                    end
                end
                S_GV_CHK: begin
                    if (vis || i_rd_data != r_ref) begin
                        r_ju    <= '0;
                        r_mv    <= '0;
                        r_state <= S_MARK;
                    end else if (r_ju + CW'(1) == r_w) begin
                        r_h     <= r_h + CW'(1);
                        r_ju    <= '0;
                        r_state <= S_GV;
                    end else begin
                        r_ju    <= r_ju + CW'(1);
                        r_state <= S_GV;
                    end
                end
                S_MARK: begin
                    // One covered cell per cycle, row by row.
                    if (r_ju + CW'(1) != r_w) begin
                        r_ju <= r_ju + CW'(1);
                    end else if (r_mv + CW'(1) != r_h) begin
                        r_ju <= '0;
                        r_mv <= r_mv + CW'(1);
                    end else if (r_pend_v) begin
                        r_state <= S_PUSH;
                    end else begin
                        r_pend_v    <= 1'b1;
                        r_pend_su   <= r_iu;
                        r_pend_sv   <= r_iv;
                        r_pend_eu   <= r_w;
                        r_pend_ev   <= r_h;
                        r_pend_cell <= r_ref;
                        if (scan_end) begin
                            r_state <= S_FINAL;
                        end else begin
                            r_iu    <= last_u ? '0 : r_iu + CW'(1);
                            r_iv    <= last_u ? r_iv + CW'(1) : r_iv;
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_PUSH: begin
                    if (i_push_ready) begin
                        r_pend_su   <= r_iu;
                        r_pend_sv   <= r_iv;
                        r_pend_eu   <= r_w;
                        r_pend_ev   <= r_h;
                        r_pend_cell <= r_ref;
                        if (scan_end) begin
                            r_state <= S_FINAL;
                        end else begin
                            r_iu    <= last_u ? '0 : r_iu + CW'(1);
                            r_iv    <= last_u ? r_iv + CW'(1) : r_iv;
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_FINAL: begin
                    if (i_push_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // A start, which the top level raises only while idle, launches a scan in the next cycle.
    a_start_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> (r_state == S_SCAN))
        else $error("merge did not start after last cell");

    // A finished rectangle never reaches past the mask edges.
    a_rect_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MARK) |->
            (({1'b0, r_iu} + {1'b0, r_w}) <= (CW+1)'(MASK_U)) &&
            (({1'b0, r_iv} + {1'b0, r_h}) <= (CW+1)'(MASK_V)))
        else $error("rectangle exceeds mask");

    // The final transaction of a slice returns the sequencer to idle.
    a_final_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINAL && i_push_ready) |=> (r_state == S_IDLE))
        else $error("sequencer did not return to idle");

endmodule

// ===== src/greedy_face_mask_merger.sv =====
// Top level of the greedy face mask merger: cell loading, register port, output stage.
//
//   Channel   Direction  Handshake                Payload
//   in        input      i_in_valid/o_in_stall    t_in_item (one mask cell)
//   out       output     o_out_valid/i_out_stall  t_out_item (one rectangle)
//   config    input      APB write/read           water_texture at byte 0
//
// A cell that is not last is taken whenever the input is not stalled. The last cell starts a merge
// that reads the cell and visited RAMs through one shared address: it scans each cell, tests cells
// while growing a rectangle along u and then along v, marks every covered cell, and hands each
// rectangle (or a marker for an empty mask) over when the output is free.
// After reset a clearing pass over all MASK_U*MASK_V entries (64 by default) zeroes the visited
// map. The input is stalled during that pass and for the whole merge. Reset is synchronous;
// the cell RAM is not cleared.
// A stalled output holds its transaction while the merge keeps running until it
// has a further rectangle to hand over.
`timescale 1ns / 1ps
module greedy_face_mask_merger #(
    parameter int MASK_U = gfm_pkg::MaskUDef,
    parameter int MASK_V = gfm_pkg::MaskVDef
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  gfm_pkg::t_in_item i_in,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output gfm_pkg::t_out_item o_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import gfm_pkg::*;

    localparam int Cells = MASK_U * MASK_V;
    localparam int AW    = $clog2(Cells);
    localparam int LW    = $clog2(Cells + 1);

    logic [LW-1:0] r_load_idx;
    logic [7:0]    r_water;
    logic          r_out_v;
    t_out_item     r_out;

    logic          in_acc, we, start, busy, push_ready;
    logic [AW-1:0] rd_addr;
    t_cell         rd_data;
    t_push         push;

    assign o_in_stall = busy;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign we         = in_acc && (r_load_idx < LW'(Cells));
    assign start      = in_acc && i_in.last_cell;

    // Cell store.
    gfm_ram #(.W(16), .D(Cells)) u_cells (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_load_idx[AW-1:0]),
        .i_wdata (encode_cell(i_in.face_code, i_in.occluders)),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    // Merge sequencer.
    gfm_merge_seq #(.MASK_U(MASK_U), .MASK_V(MASK_V)) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_water      (r_water),
        .o_rd_addr    (rd_addr),
        .i_rd_data    (rd_data),
        .o_push       (push),
        .i_push_ready (push_ready),
        .o_busy       (busy)
    );

    // Load index saturates at the mask size and rewinds after the last cell.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_idx <= '0;
        end else if (start) begin
            r_load_idx <= '0;
        end else if (we) begin
            r_load_idx <= r_load_idx + LW'(1);
        end
    end

    // Register port.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_water <= WaterReset;
        end else if (psel && penable && pwrite && pready && paddr[2] == AddrWater[2]) begin
            r_water <= pwdata[7:0];
        end
    end

    assign prdata = (paddr[2] == AddrWater[2]) ? {24'd0, r_water} : 32'd0;
    assign pready = 1'b1;

    // Output register.
    assign push_ready = !r_out_v || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (push.valid && push_ready) begin
            r_out_v <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push.valid && push_ready) begin
            r_out <= push.item;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out       = r_out;

endmodule

// ===== dv/gfm_rect_checker.sv =====
// Checker for the greedy face mask merger: predicts rectangles and compares them.
`timescale 1ns / 1ps
module gfm_rect_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  gfm_pkg::t_in_item   i_in,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  gfm_pkg::t_out_item  i_out,
    input  logic                i_psel,
    input  logic                i_penable,
    input  logic                i_pwrite,
    input  logic                i_pready,
    input  logic [2:0]          i_paddr,
    input  logic [31:0]         i_pwdata,
    output int                  o_fail_count,
    output int                  o_pending
);
    import gfm_pkg::*;

    localparam int Cells = MaskUDef * MaskVDef;

    logic [15:0]  mask_cells [Cells];
    int           fill_index;
    logic [7:0]   water_tex;
    t_out_item    expected_rects[$];
    int           fail_count;

    assign o_fail_count = fail_count;

    initial fail_count = 0;
    initial o_pending  = 0;

    // Occlusion level of one corner: both sides set is fully dark.
    function automatic logic [1:0] occl_level(input logic [2:0] bits);
        int lit;
        if (bits[0] && bits[1]) begin
            return 2'd0;
        end
        lit = 3 - int'(bits[0]) - int'(bits[1]) - int'(bits[2]);
        return lit[1:0];
    endfunction

    // Builds the expected rectangle for one merged region.
    function automatic t_out_item rect_of(input int su, input int sv, input int eu,
                                          input int ev, input logic [15:0] c);
        t_out_item r;
        r.start_u       = su[2:0];
        r.start_v       = sv[2:0];
        r.extent_u      = eu[3:0];
        r.extent_v      = ev[3:0];
        r.texture       = c[7:0] - 8'd1;
        r.level_c0      = c[9:8];
        r.level_c1      = c[11:10];
        r.level_c2      = c[13:12];
        r.level_c3      = c[15:14];
        r.diagonal_flip = (int'(c[9:8]) + int'(c[13:12])) > (int'(c[11:10]) + int'(c[15:14]));
        r.water_face    = (r.texture == water_tex);
        r.last_rect     = 1'b0;
        return r;
    endfunction

    // Greedy scan of the stored mask: grow along u, then along v.
    task automatic merge_rects();
        bit [Cells-1:0] seen;
        int             count;
        int             w;
        int             h;
        bit             blocked;
        logic [15:0]    ref_cell;
        t_out_item      r;
        seen  = '0;
        count = 0;
        for (int v = 0; v < MaskVDef; v++) begin
            for (int u = 0; u < MaskUDef; u++) begin
                ref_cell = mask_cells[v * MaskUDef + u];
                if (seen[v * MaskUDef + u] || ref_cell[7:0] == 8'd0) continue;
                w = 1;
                while (u + w < MaskUDef && !seen[v * MaskUDef + u + w] &&
                       mask_cells[v * MaskUDef + u + w] == ref_cell) w++;
                h = 1;
                blocked = 0;
                while (v + h < MaskVDef && !blocked) begin
                    for (int j = 0; j < w; j++) begin
                        if (seen[(v + h) * MaskUDef + u + j] ||
                            mask_cells[(v + h) * MaskUDef + u + j] != ref_cell) blocked = 1;
                    end
                    if (!blocked) h++;
                end
                for (int a = 0; a < h; a++) begin
                    for (int b = 0; b < w; b++) seen[(v + a) * MaskUDef + u + b] = 1;
                end
                expected_rects = {expected_rects, rect_of(u, v, w, h, ref_cell)};
                count++;
            end
        end
        if (count == 0) begin
            r = '0;
            r.last_rect = 1'b1;
            expected_rects = {expected_rects, r};
        end else begin
            expected_rects[expected_rects.size() - 1].last_rect = 1'b1;
        end
    endtask

    // Prints one mismatch line and counts it.
    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] mismatch %s: got %0d expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    // Tracks register writes, loaded cells and delivered rectangles.
    always @(posedge i_clk) begin
        t_out_item   want;
        logic [15:0] c;
        if (!i_rst_n) begin
            fill_index = 0;
            water_tex  = WaterReset;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr[2] == AddrWater[2]) begin
                water_tex = i_pwdata[7:0];
            end
            if (i_in_valid && !i_in_stall) begin
                if (fill_index < Cells) begin
                    c[7:0] = i_in.face_code;
                    for (int k = 0; k < 4; k++) c[8 + 2 * k +: 2] = occl_level(i_in.occluders[3 * k +: 3]);
                    mask_cells[fill_index] = c;
                    fill_index++;
                end
                if (i_in.last_cell) begin
                    merge_rects();
                    fill_index = 0;
                end
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_rects.size() == 0) begin
                    $display("[%0t] unexpected rectangle transaction", $realtime);
                    fail_count++;
                end else begin
                    want = expected_rects.pop_front();
                    if (i_out.start_u != want.start_u)
                        report_mismatch("start_u", i_out.start_u, want.start_u);
                    if (i_out.start_v != want.start_v)
                        report_mismatch("start_v", i_out.start_v, want.start_v);
                    if (i_out.extent_u != want.extent_u)
                        report_mismatch("extent_u", i_out.extent_u, want.extent_u);
                    if (i_out.extent_v != want.extent_v)
                        report_mismatch("extent_v", i_out.extent_v, want.extent_v);
                    if (i_out.texture != want.texture)
                        report_mismatch("texture", i_out.texture, want.texture);
                    if (i_out.level_c0 != want.level_c0)
                        report_mismatch("level_c0", i_out.level_c0, want.level_c0);
                    if (i_out.level_c1 != want.level_c1)
                        report_mismatch("level_c1", i_out.level_c1, want.level_c1);
                    if (i_out.level_c2 != want.level_c2)
                        report_mismatch("level_c2", i_out.level_c2, want.level_c2);
                    if (i_out.level_c3 != want.level_c3)
                        report_mismatch("level_c3", i_out.level_c3, want.level_c3);
                    if (i_out.diagonal_flip !== want.diagonal_flip)
                        report_mismatch("diagonal_flip", i_out.diagonal_flip, want.diagonal_flip);
                    if (i_out.water_face !== want.water_face)
                        report_mismatch("water_face", i_out.water_face, want.water_face);
                    if (i_out.last_rect !== want.last_rect)
                        report_mismatch("last_rect", i_out.last_rect, want.last_rect);
                end
            end
        end
        o_pending = expected_rects.size();
    end
endmodule

// ===== dv/tb_top.sv =====
// Testbench top for the greedy face mask merger: stimulus, register writes and verdict.
`timescale 1ns / 1ps
module tb_top;
    import gfm_pkg::*;

    localparam int Cells      = MaskUDef * MaskVDef;
    localparam int CycleLimit = 3000000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in_item    i_in;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out_item   o_out;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int          fail_count;
    int          pending;
    int          cycle_count;
    int          cells_sent;
    int          burst_left;
    int          stall_mode;
    int          stall_span;

    // Slice palette used for structured and uniform masks.
    logic [7:0]  pal_face [4];
    logic [11:0] pal_occ  [4];

    greedy_face_mask_merger dut (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_stall, .i_in, .o_out_valid, .i_out_stall,
        .o_out, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    gfm_rect_checker u_checker (
        .i_clk, .i_rst_n, .i_in_valid, .i_in_stall(o_in_stall), .i_in,
        .i_out_valid(o_out_valid), .i_out_stall, .i_out(o_out),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_pready(pready),
        .i_paddr(paddr), .i_pwdata(pwdata), .o_fail_count(fail_count), .o_pending(pending)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Run limit.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("greedy_face_mask_merger regression: fail");
            $finish;
        end
    end

    // Receiver stall pattern: stretches of no stall, random stall and long stall runs.
    always @(negedge i_clk) begin
        if (stall_span == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_span <= $urandom_range(10, 80);
        end else begin
            stall_span <= stall_span - 1;
        end
        case (stall_mode)
            0: i_out_stall <= 1'b0;
            1: i_out_stall <= ($urandom_range(0, 1) == 0);
            2: i_out_stall <= ($urandom_range(0, 7) != 0);
            default: i_out_stall <= ($urandom_range(0, 5) == 0);
        endcase
    end

    // Sends one cell transaction, with bursts and random gaps ahead of it.
    // Valid stays high on return; the next call or the caller replaces or drops it.
    task automatic send_cell(input logic [7:0] face, input logic [11:0] occ, input logic last);
        bit taken;
        if (burst_left == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? 200 : $urandom_range(1, 16);
        end
        burst_left--;
        i_in_valid          <= 1'b1;
        i_in.face_code      <= face;
        i_in.occluders      <= occ;
        i_in.last_cell      <= last;
        taken = 0;
        while (!taken) begin
            @(posedge i_clk);
            taken = !o_in_stall;
        end
        cells_sent++;
        @(negedge i_clk);
    endtask

    // Writes the water texture register through the setup and access phases.
    task automatic write_water(input logic [7:0] tex);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= AddrWater;
        pwdata  <= {$urandom_range(0, 1) ? 24'hFFFFFF : 24'h0, tex};
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Holds input until every expected rectangle has come, then lets the merge settle.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    // One slice: style picks structured, random, empty or uniform content.
    task automatic send_slice(input int style, input int len);
        int          bu;
        int          bv;
        int          sel;
        logic [7:0]  face;
        logic [11:0] occ;
        bu = $urandom_range(0, 3);
        bv = $urandom_range(0, 3);
        for (int k = 0; k < 4; k++) begin
            pal_face[k] = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(1, 4));
            pal_occ[k]  = 12'($urandom);
        end
        if ($urandom_range(0, 5) == 0) pal_face[0] = 8'hFF;
        for (int i = 0; i < len; i++) begin
            sel = (((i % MaskUDef) >> bu) + ((i / MaskUDef) >> bv) * 3) % 4;
            case (style)
                0: begin
                    face = pal_face[sel];
                    occ  = pal_occ[sel];
                end
                1: begin
                    face = 8'($urandom);
                    occ  = 12'($urandom);
                end
                2: begin
                    face = 8'd0;
                    occ  = 12'($urandom);
                end
                default: begin
                    face = pal_face[1] | 8'd1;
                    occ  = pal_occ[1];
                end
            endcase
            send_cell(face, occ, i == len - 1);
        end
    endtask

    initial begin
        int style;
        int len;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in        = '0;
        i_out_stall = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        cycle_count = 0;
        cells_sent  = 0;
        burst_left  = 0;
        stall_mode  = 0;
        stall_span  = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Largest texture flagged as water, then a full slice so every entry is written.
        write_water(8'd254);
        send_slice(0, Cells);

        // Single-cell slices over every corner code, then a two-cell slice; together they use the extreme face codes.
        for (int k = 0; k < 8; k++) begin
            send_cell((k == 0) ? 8'hFF : 8'(k + 1), {4{3'(k)}}, 1'b1);
        end
        send_cell(8'd1, 12'h000, 1'b0);
        send_cell(8'd1, 12'hFFF, 1'b1);
        drain();
        write_water(8'd0);
        send_slice(3, Cells);
        send_slice(2, Cells);

        // Random slices, with a register change at each phase boundary.
        while (cells_sent < 300) begin
            if ($urandom_range(0, 3) == 0) begin
                drain();
                case ($urandom_range(0, 3))
                    0: write_water(8'd0);
                    1: write_water(8'd254);
                    2: write_water(8'd5);
                    default: write_water(8'($urandom_range(0, 254)));
                endcase
            end
            style = $urandom_range(0, 9);
            style = (style < 5) ? 0 : (style < 7) ? 1 : (style < 8) ? 2 : 3;
            case ($urandom_range(0, 9))
                0, 1, 2, 3: len = Cells;
                4:          len = $urandom_range(Cells + 1, Cells + 8);
                5:          len = $urandom_range(1, 3);
                default:    len = $urandom_range(4, Cells - 1);
            endcase
            send_slice(style, len);
        end

        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("greedy_face_mask_merger regression: pass");
        end else begin
            $display("greedy_face_mask_merger regression: fail");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
src/gfm_pkg.sv
src/gfm_ram.sv
src/gfm_merge_seq.sv
src/greedy_face_mask_merger.sv
dv/gfm_rect_checker.sv
dv/tb_top.sv
